/* hdl/epc_pkg.sv */
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types and constants of the Euler path existence check.
// ----------------------------------------------------------------------------
package epc_pkg;

	localparam int LETTER_W = 5;
	localparam int COUNT_OUT_W = 5;
	localparam logic [COUNT_OUT_W-1:0] LETTERS_MAX = '1;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_EVAL,
		ST_FIN
	} epc_state_t;

	typedef struct packed {
		logic item_ready;
		logic eval_start;
		logic add_wr;
		logic issue_en;
		logic sweep_end;
		logic fin_load;
	} epc_ctrl_t;

endpackage

/* hdl/epc_if.sv */
// ----------------------------------------------------------------------------
// epc_item_if / epc_result_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface epc_item_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [epc_pkg::LETTER_W-1:0] first_letter;
	logic [epc_pkg::LETTER_W-1:0] last_letter;

	modport source (output valid, cmd, first_letter, last_letter, input ready);
	modport sink (input valid, cmd, first_letter, last_letter, output ready);
endinterface

interface epc_result_if;
	logic valid;
	logic ready;
	logic ordering_possible;
	logic [epc_pkg::COUNT_OUT_W-1:0] letters_used;

	modport source (output valid, ordering_possible, letters_used, input ready);
	modport sink (input valid, ordering_possible, letters_used, output ready);
endinterface

/* hdl/epc_ram.sv */
// ----------------------------------------------------------------------------
// epc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module epc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 26
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/euler_path_existence_check.sv */
// ----------------------------------------------------------------------------
// euler_path_existence_check
// Collects directed letter edges and decides whether an Eulerian path exists.
// ----------------------------------------------------------------------------
// An add word reads the node's degree/adjacency entry when it is taken and
// writes it back in ST_ADD; an add with a letter out of range is taken and dropped.
// An evaluate word walks the node tables through their single read port, one
// node per cycle, in sweeps over all ALPHABET nodes; the first sweep checks the
// degrees and counts letters, and sweeps repeat until the reached set stops
// growing, so 1 to ALPHABET sweeps; the store is then cleared when ST_FIN
// loads the result into the output register. The result sits there while the next
// word is taken; no reset clearing pass is needed.
module euler_path_existence_check #(
	parameter int ALPHABET = 26,
	parameter int COUNT_WIDTH = 16
) (
	input logic           clk,
	input logic           arst_n,
	epc_item_if.sink      item,
	epc_result_if.source  result
);

	localparam int AW = $clog2(ALPHABET);
	localparam int CNTW = $clog2(ALPHABET + 1);
	localparam int OW = COUNT_WIDTH + ALPHABET;
	localparam int EXTW = epc_pkg::COUNT_OUT_W + 1;
	localparam logic [epc_pkg::LETTER_W:0] ALPHA_L = (epc_pkg::LETTER_W + 1)'(ALPHABET);
	localparam logic [AW-1:0] LAST_IDX = AW'(ALPHABET - 1);

	epc_pkg::epc_state_t state_q, state_nx;
	epc_pkg::epc_ctrl_t  ctrl;

	logic [AW-1:0]       u_s1, v_s1;
	logic [ALPHABET-1:0] out_vld_q, in_vld_q, used_q, reached_q;
	logic [AW-1:0]       iss_q;
	logic                iss_active_q;
	logic                rd_vld_s1, rd_last_s1;
	logic [AW-1:0]       rd_idx_s1;
	logic                first_q, changed_q, bad_q, head_q, tail_q;
	logic [CNTW-1:0]     cnt_q;
	logic                oval_q, ok_q;
	logic [epc_pkg::COUNT_OUT_W-1:0] let_q;

	logic                 add_in_range;
	logic [AW-1:0]        out_raddr, in_raddr;
	logic                 out_we, in_we;
	logic [OW-1:0]        out_wdata, out_rdata;
	logic [COUNT_WIDTH-1:0] in_wdata, in_rdata;

	logic [COUNT_WIDTH-1:0] cur_out, cur_in;
	logic [ALPHABET-1:0]    cur_row, v_hot, i_hot, reached_nx;
	logic                   chg_now;
	logic [COUNT_WIDTH:0]   o_x, n_x;
	logic                   is_head, is_tail, is_bad;
	logic [EXTW-1:0]        cnt_x;

	assign add_in_range = ({1'b0, item.first_letter} < ALPHA_L)
		&& ({1'b0, item.last_letter} < ALPHA_L);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			epc_pkg::ST_IDLE: begin
				if (item.valid && item.cmd == epc_pkg::CMD_EVAL) begin
					state_nx = epc_pkg::ST_EVAL;
				end else if (item.valid && add_in_range) begin
					state_nx = epc_pkg::ST_ADD;
				end
			end
			epc_pkg::ST_ADD: state_nx = epc_pkg::ST_IDLE;
			epc_pkg::ST_EVAL: begin
				if (rd_vld_s1 && rd_last_s1 && !(changed_q || chg_now)) begin
					state_nx = epc_pkg::ST_FIN;
				end
			end
			epc_pkg::ST_FIN: begin
				if (!oval_q || result.ready) begin
					state_nx = epc_pkg::ST_IDLE;
				end
			end
			default: state_nx = epc_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			epc_pkg::ST_IDLE: begin
				ctrl.item_ready = 1'b1;
				ctrl.eval_start = item.valid && item.cmd == epc_pkg::CMD_EVAL;
			end
			epc_pkg::ST_ADD: ctrl.add_wr = 1'b1;
			epc_pkg::ST_EVAL: begin
				ctrl.issue_en = iss_active_q;
				ctrl.sweep_end = rd_vld_s1 && rd_last_s1;
			end
			epc_pkg::ST_FIN: ctrl.fin_load = !oval_q || result.ready;
			default: ctrl = '0;
		endcase
	end

	assign item.ready = ctrl.item_ready;

	// memory ports
	assign out_raddr = (state_q == epc_pkg::ST_EVAL) ? iss_q : item.first_letter[AW-1:0];
	assign in_raddr = (state_q == epc_pkg::ST_EVAL) ? iss_q : item.last_letter[AW-1:0];

	always_comb begin
		v_hot = '0;
		v_hot[v_s1] = 1'b1;
		i_hot = '0;
		i_hot[rd_idx_s1] = 1'b1;
	end

	always_comb begin
		logic [AW-1:0] a_out, a_in;
		a_out = ctrl.add_wr ? u_s1 : rd_idx_s1;
		a_in = ctrl.add_wr ? v_s1 : rd_idx_s1;
		cur_out = out_vld_q[a_out] ? out_rdata[OW-1:ALPHABET] : '0;
		cur_row = out_vld_q[a_out] ? out_rdata[ALPHABET-1:0] : '0;
		cur_in = in_vld_q[a_in] ? in_rdata : '0;
	end

	assign out_we = ctrl.add_wr;
	assign in_we = ctrl.add_wr;
	assign out_wdata = {(&cur_out) ? cur_out : cur_out + 1'b1, cur_row | v_hot};
	assign in_wdata = (&cur_in) ? cur_in : cur_in + 1'b1;

	epc_ram #(.WIDTH(OW), .DEPTH(ALPHABET)) u_out_ram (
		.clk   (clk),
		.we    (out_we),
		.waddr (u_s1),
		.wdata (out_wdata),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	epc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (v_s1),
		.wdata (in_wdata),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	// sweep datapath: reach both ways along each stored row
	assign reached_nx = reached_q | (reached_q[rd_idx_s1] ? cur_row : '0)
		| (|(cur_row & reached_q) ? i_hot : '0);
	assign chg_now = rd_vld_s1 && (reached_nx != reached_q);

	assign o_x = {1'b0, cur_out};
	assign n_x = {1'b0, cur_in};
	assign is_head = o_x == n_x + 1'b1;
	assign is_tail = n_x == o_x + 1'b1;
	assign is_bad = (o_x != n_x) && !is_head && !is_tail;

	assign cnt_x = EXTW'(cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= epc_pkg::ST_IDLE;
			out_vld_q <= '0;
			in_vld_q <= '0;
			used_q <= '0;
			reached_q <= '0;
			iss_q <= '0;
			iss_active_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			first_q <= 1'b0;
			changed_q <= 1'b0;
			bad_q <= 1'b0;
			head_q <= 1'b0;
			tail_q <= 1'b0;
			cnt_q <= '0;
			oval_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			rd_vld_s1 <= ctrl.issue_en;

			if (ctrl.add_wr) begin
				out_vld_q[u_s1] <= 1'b1;
				in_vld_q[v_s1] <= 1'b1;
				used_q[u_s1] <= 1'b1;
				used_q[v_s1] <= 1'b1;
			end

			if (ctrl.eval_start) begin
				reached_q <= used_q & (~used_q + 1'b1);
				iss_q <= '0;
				iss_active_q <= 1'b1;
				first_q <= 1'b1;
				changed_q <= 1'b0;
				bad_q <= 1'b0;
				head_q <= 1'b0;
				tail_q <= 1'b0;
				cnt_q <= '0;
			end else if (ctrl.issue_en) begin
				if (iss_q == LAST_IDX) begin
					iss_active_q <= 1'b0;
				end else begin
					iss_q <= iss_q + 1'b1;
				end
			end

			if (rd_vld_s1) begin
				reached_q <= reached_nx;
				if (first_q) begin
					if (is_bad || (is_head && head_q) || (is_tail && tail_q)) begin
						bad_q <= 1'b1;
					end
					if (is_head) begin
						head_q <= 1'b1;
					end
					if (is_tail) begin
						tail_q <= 1'b1;
					end
					if (used_q[rd_idx_s1]) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				if (ctrl.sweep_end) begin
					first_q <= 1'b0;
					changed_q <= 1'b0;
					if (changed_q || chg_now) begin
						iss_q <= '0;
						iss_active_q <= 1'b1;
					end
				end else if (chg_now) begin
					changed_q <= 1'b1;
				end
			end

			if (ctrl.fin_load) begin
				oval_q <= 1'b1;
				out_vld_q <= '0;
				in_vld_q <= '0;
				used_q <= '0;
				reached_q <= '0;
			end else if (result.valid && result.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && ctrl.item_ready) begin
			u_s1 <= item.first_letter[AW-1:0];
			v_s1 <= item.last_letter[AW-1:0];
		end
		rd_idx_s1 <= iss_q;
		rd_last_s1 <= iss_q == LAST_IDX;
		if (ctrl.fin_load) begin
			ok_q <= !bad_q && ((reached_q & used_q) == used_q);
			let_q <= (cnt_x > EXTW'(epc_pkg::LETTERS_MAX)) ? epc_pkg::LETTERS_MAX
				: cnt_x[epc_pkg::COUNT_OUT_W-1:0];
		end
	end

	assign result.valid = oval_q;
	assign result.ordering_possible = ok_q;
	assign result.letters_used = let_q;

endmodule

/* hdl/epc_checker.sv */
// ----------------------------------------------------------------------------
// epc_checker
// Port-level checks of the Euler path existence check.
// ----------------------------------------------------------------------------
module epc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic                               item_cmd,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic                               res_ok,
	input logic [epc_pkg::COUNT_OUT_W-1:0]    res_letters
);

	// an accepted evaluate word occupies the block and drops input ready
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_cmd == epc_pkg::CMD_EVAL |=> !item_ready)
		else $error("input ready straight after an accepted evaluate word");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_ok) && $stable(res_letters))
		else $error("stalled result word changed");

	a_empty_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_letters == '0 |-> res_ok)
		else $error("empty edge set rejected");

	a_single_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_letters == epc_pkg::COUNT_OUT_W'(1) |-> res_ok)
		else $error("single-letter set rejected");

endmodule

bind euler_path_existence_check epc_checker u_epc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.item_cmd    (item.cmd),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_ok      (result.ordering_possible),
	.res_letters (result.letters_used)
);
